// ===== rtl/uf2bsc_pkg.sv =====
package uf2bsc_pkg;

  localparam int unsigned PayloadBytes = 256;
  localparam int unsigned BlockBytes   = 512;
  localparam int unsigned SectorBytes  = 4096;

  localparam int unsigned BlockShift   = $clog2(BlockBytes);
  localparam int unsigned PayloadShift = $clog2(PayloadBytes);

  localparam logic [31:0] MagicFirst   = 32'h0A32_4655;
  localparam logic [31:0] MagicSecond  = 32'h9E5D_5157;
  localparam logic [31:0] MagicFinal   = 32'h0AB1_6F30;
  localparam int unsigned FlagNotFlash = 0;
  localparam int unsigned FlagFamily   = 13;
  localparam logic [39:0] MinImageBytes = 40'd16384;

  localparam logic [31:0] FamilyIdRst    = 32'hE48B_FF56;
  localparam logic [31:0] FlashBaseRst   = 32'h1000_0000;
  localparam logic [31:0] StagingSizeRst = 32'h0010_0000;
  localparam logic        DeriveTotalRst = 1'b1;
  localparam logic [31:0] PresetTotalRst = 32'h0000_0000;

  localparam int unsigned InDataW  = 288;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    V_PROGRAM      = 3'd0,
    V_OTHER_FAMILY = 3'd1,
    V_NOT_FLASH    = 3'd2,
    V_BAD_MAGIC    = 3'd3,
    V_BAD_SIZE     = 3'd4,
    V_OUT_OF_RANGE = 3'd5,
    V_OUT_OF_ORDER = 3'd6
  } verdict_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_FAMILY_ID    = 3'd0,
    REG_FLASH_BASE   = 3'd1,
    REG_STAGING_SIZE = 3'd2,
    REG_DERIVE_TOTAL = 3'd3,
    REG_PRESET_TOTAL = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] family_id;
    logic [31:0] flash_base;
    logic [31:0] staging_size;
    logic        derive_total;
    logic [31:0] preset_total;
  } cfg_t;

  typedef struct packed {
    logic [31:0] family_word;
    logic [31:0] block_total;
    logic [31:0] block_number;
    logic [31:0] payload_length;
    logic [31:0] target_address;
    logic [31:0] block_flags;
    logic [31:0] magic_final;
    logic [31:0] magic_second;
    logic [31:0] magic_first;
  } item_t;

  typedef struct packed {
    logic        led_level;
    logic        image_ready;
    logic [47:0] byte_estimate;
    logic [31:0] error_count;
    logic [31:0] blocks_done;
    logic        erase_sector;
    logic [31:0] staging_offset;
    verdict_e    verdict;
  } result_t;

endpackage

// ===== rtl/uf2bsc_core.sv =====
module uf2bsc_core #(
  parameter int unsigned SectorBytes = uf2bsc_pkg::SectorBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  uf2bsc_pkg::item_t   item_i,
  input  uf2bsc_pkg::cfg_t    cfg_i,
  output uf2bsc_pkg::result_t result_o
);
  import uf2bsc_pkg::*;

  localparam int unsigned SectorLsb = $clog2(SectorBytes);

  logic [31:0] accepted_q, accepted_d;
  logic [31:0] expected_q, expected_d;
  logic [31:0] reject_q, reject_d;
  logic [47:0] derived_q, derived_d;
  result_t     result_q, result_d;

  logic        magic_ok;
  logic        family_ok;
  logic [48:0] derived_sum;
  logic [32:0] window_end;
  logic        out_of_range;
  logic [31:0] woff;
  logic [39:0] image_bytes;
  logic        ready;
  verdict_e    verdict;

  assign magic_ok = (item_i.magic_first == MagicFirst) &&
                    (item_i.magic_second == MagicSecond) &&
                    (item_i.magic_final == MagicFinal);
  assign family_ok = (item_i.family_word == cfg_i.family_id) &&
                     item_i.block_flags[FlagFamily];
  assign derived_sum = {1'b0, derived_q} +
                       {8'b0, item_i.block_total, {BlockShift{1'b0}}};
  assign window_end = {1'b0, cfg_i.flash_base} + {1'b0, cfg_i.staging_size};
  assign out_of_range = (item_i.target_address < cfg_i.flash_base) ||
                        ({1'b0, item_i.target_address} >= window_end);
  assign woff = item_i.target_address - cfg_i.flash_base;

  always_comb begin
    accepted_d = accepted_q;
    expected_d = expected_q;
    reject_d   = reject_q;
    derived_d  = derived_q;
    verdict    = V_PROGRAM;

    if (magic_ok && cfg_i.derive_total && (item_i.block_number == '0) &&
        (item_i.block_total != '0)) begin
      derived_d = derived_sum[48] ? {48{1'b1}} : derived_sum[47:0];
    end

    if (!magic_ok) begin
      verdict = V_BAD_MAGIC;
    end else if (!family_ok) begin
      verdict = V_OTHER_FAMILY;
    end else if (item_i.block_flags[FlagNotFlash]) begin
      verdict = V_NOT_FLASH;
    end else if (item_i.payload_length != 32'(PayloadBytes)) begin
      verdict = V_BAD_SIZE;
    end else if (out_of_range) begin
      verdict = V_OUT_OF_RANGE;
    end else if (item_i.block_number == '0) begin
      expected_d = item_i.block_total;
      accepted_d = 32'd1;
    end else if (item_i.block_number != accepted_q) begin
      verdict = V_OUT_OF_ORDER;
    end else begin
      accepted_d = accepted_q + 32'd1;
    end

    if (verdict == V_BAD_MAGIC || verdict == V_BAD_SIZE ||
        verdict == V_OUT_OF_RANGE || verdict == V_OUT_OF_ORDER) begin
      reject_d = reject_q + 32'd1;
    end

    image_bytes = {expected_d, {PayloadShift{1'b0}}};
    ready = (expected_d != '0) && (accepted_d == expected_d) &&
            (image_bytes >= MinImageBytes) &&
            (image_bytes <= {8'b0, cfg_i.staging_size});

    result_d.verdict        = verdict;
    result_d.staging_offset = (verdict == V_PROGRAM) ? cfg_i.staging_size + woff : '0;
    result_d.erase_sector   = (verdict == V_PROGRAM) && (woff[SectorLsb-1:0] == '0);
    result_d.blocks_done    = accepted_d;
    result_d.error_count    = reject_d;
    result_d.byte_estimate  = cfg_i.derive_total ? derived_d : {16'b0, cfg_i.preset_total};
    result_d.image_ready    = ready;
    result_d.led_level      = accepted_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_q <= '0;
      expected_q <= '0;
      reject_q   <= '0;
      derived_q  <= '0;
    end else if (load_i) begin
      accepted_q <= accepted_d;
      expected_q <= expected_d;
      reject_q   <= reject_d;
      derived_q  <= derived_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== rtl/uf2_block_sequence_checker.sv =====
// A header word accepted on the input is held in the input register and then, when the
// output is free, moves on to the result register that drives m_tdata_o.
// Throughput: one word per cycle while the output is not stalled; both stages advance whenever the output is free.
// Reset clears the counters and both valid flags and loads the register defaults.
module uf2_block_sequence_checker #(
  parameter int unsigned SectorBytes = uf2bsc_pkg::SectorBytes
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  // magic_first, magic_second, magic_final, block_flags, target_address,
  // payload_length, block_number, block_total, family_word (32 bits each)
  input  logic [uf2bsc_pkg::InDataW-1:0]      s_tdata_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  // verdict 3, staging_offset 32, erase_sector 1, blocks_done 32,
  // error_count 32, byte_estimate 48, image_ready 1, led_level 1, 2 zero bits
  output logic [uf2bsc_pkg::OutDataW-1:0]     m_tdata_o,
  input  logic                                cfg_we_i,
  input  logic [uf2bsc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [uf2bsc_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import uf2bsc_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    out_adv;
  logic    load;
  result_t result;

  assign out_adv    = !out_valid_q || m_tready_i;
  assign load       = in_valid_q && out_adv;
  assign s_tready_o = !in_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.family_id    <= FamilyIdRst;
      cfg_q.flash_base   <= FlashBaseRst;
      cfg_q.staging_size <= StagingSizeRst;
      cfg_q.derive_total <= DeriveTotalRst;
      cfg_q.preset_total <= PresetTotalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FAMILY_ID:    cfg_q.family_id    <= cfg_wdata_i;
        REG_FLASH_BASE:   cfg_q.flash_base   <= cfg_wdata_i;
        REG_STAGING_SIZE: cfg_q.staging_size <= cfg_wdata_i;
        REG_DERIVE_TOTAL: cfg_q.derive_total <= cfg_wdata_i[0];
        REG_PRESET_TOTAL: cfg_q.preset_total <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      item_q <= item_t'(s_tdata_i);
    end
  end

  uf2bsc_core #(
    .SectorBytes(SectorBytes)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, result};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && result.verdict != V_PROGRAM) |->
      (result.staging_offset == '0 && !result.erase_sector))
    else $error("placement given on a skipped or rejected block");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && result.verdict == V_PROGRAM) |-> (result.blocks_done != '0))
    else $error("programmed block left the accepted count at zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (result.led_level == result.blocks_done[0]))
    else $error("LED level disagrees with the accepted count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(result)))
    else $error("stalled result changed");

endmodule
